// ===== hdl/slicvf_pkg.sv =====
// ----------------------------------------------------------------------------
// slicvf_pkg
// Shared types and codes for the SLIC vertical flux pipeline.
// ----------------------------------------------------------------------------
package slicvf_pkg;

    localparam int unsigned ONE_Q16 = 65536;

    // interface_case codes
    localparam logic [2:0] KIND_NONE      = 3'd0;
    localparam logic [2:0] KIND_TYPE1     = 3'd1;
    localparam logic [2:0] KIND_II_BELOW  = 3'd2;
    localparam logic [2:0] KIND_II_ABOVE  = 3'd3;
    localparam logic [2:0] KIND_III_FLUID = 3'd4;
    localparam logic [2:0] KIND_III_GAP   = 3'd5;
    localparam logic [2:0] KIND_UNMATCHED = 3'd6;

    // configuration register indexes
    localparam logic [7:0] CFG_TOL = 8'd0;
    localparam logic [7:0] CFG_DT  = 8'd1;
    localparam logic [7:0] CFG_DX  = 8'd2;
    localparam logic [7:0] CFG_DY  = 8'd3;

    localparam logic [14:0] TOL_RESET = 15'd66;
    localparam logic [31:0] DT_RESET  = 32'd655;
    localparam logic [31:0] DX_RESET  = 32'd65536;
    localparam logic [31:0] DY_RESET  = 32'd65536;

    typedef struct packed {
        logic [15:0]        cell_tag;
        logic [16:0]        frac_center;
        logic [16:0]        frac_above;
        logic [16:0]        frac_below;
        logic signed [31:0] vel_top_face;
        logic signed [31:0] vel_bottom_face;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cell_tag_out;
        logic [2:0]  interface_case;
        logic [31:0] flux_top;
        logic        top_written;
        logic [31:0] flux_bottom;
        logic        bottom_written;
    } t_out_item;

    // per-face control: flux profile, fluid on the outward side, flux computed
    typedef struct packed {
        logic [2:0] prof;
        logic       ff;
        logic       wr;
    } t_face_ctl;

endpackage

// ===== hdl/slic_vof_vertical_flux.sv =====
// ----------------------------------------------------------------------------
// slic_vof_vertical_flux
// SLIC volume-of-fluid vertical flux, one grid cell per beat.
// ----------------------------------------------------------------------------
// Input beat (i_item) is taken when i_valid is high and o_stall low; result
// beat (o_item) leaves when o_valid is high and i_stall low.
// Configuration: i_cfg_index / i_cfg_data written when i_cfg_valid and
// o_cfg_ready are high (ready is always high). Index 0 tolerance, 1 time
// step, 2 cell width, 3 cell height; other indexes are dropped.
// One beat per cycle is sustained while i_stall is low. The pipeline has six
// register stages: classify, velocity and length products, profile select,
// d*w recombine, split product with dx, sum and saturate.
// Each stage holds while the stage after it is full and stalled, so bubbles
// close up; o_stall rises only when every stage is full and i_stall is high.
// Reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module slic_vof_vertical_flux
    import slicvf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [14:0] r_tol;
    logic [31:0] r_dt, r_dx, r_dy;

    logic [5:0] r_vld;
    logic [5:0] rdy;

    logic [2:0]  kind;
    logic        top_out, bot_out;
    t_face_ctl   n_ctl_t, n_ctl_b;

    logic [15:0] r_tag  [6];
    logic [2:0]  r_kind [6];
    logic [5:0]  r_tw, r_bw;
    t_face_ctl   r0_ctl_t, r0_ctl_b, r1_ctl_t, r1_ctl_b;
    logic [31:0] r0_vt, r0_vb;
    logic [15:0] r0_w, r1_w;
    logic [63:0] r1_pt, r1_pb;
    logic [47:0] r1_wf;
    logic [48:0] r1_we;
    logic [31:0] flux_t, flux_b;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
            r_dt  <= DT_RESET;
            r_dx  <= DX_RESET;
            r_dy  <= DY_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TOL: r_tol <= i_cfg_data[14:0];
                CFG_DT:  r_dt  <= i_cfg_data;
                CFG_DX:  r_dx  <= i_cfg_data;
                CFG_DY:  r_dy  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage handshake
    always_comb begin
        rdy[5] = !r_vld[5] || !i_stall;
        for (int k = 4; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_vld[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < 6; k++) begin
                if (rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage 0: classify and face direction
    slicvf_classify u_classify (
        .i_frac_c (i_item.frac_center),
        .i_frac_a (i_item.frac_above),
        .i_frac_b (i_item.frac_below),
        .i_tol    (r_tol),
        .o_kind   (kind)
    );

    always_comb begin
        top_out = (i_item.vel_top_face != 0) && !i_item.vel_top_face[31];
        bot_out = i_item.vel_bottom_face[31];
        n_ctl_t.prof = (kind == KIND_II_ABOVE) ? KIND_II_BELOW : kind;
        n_ctl_t.ff   = (kind == KIND_II_ABOVE);
        n_ctl_t.wr   = top_out && (kind != KIND_NONE) && (kind != KIND_UNMATCHED);
        n_ctl_b.prof = n_ctl_t.prof;
        n_ctl_b.ff   = (kind == KIND_II_BELOW);
        n_ctl_b.wr   = bot_out && (kind != KIND_NONE) && (kind != KIND_UNMATCHED);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r0_ctl_t  <= n_ctl_t;
            r0_ctl_b  <= n_ctl_b;
            r0_vt     <= i_item.vel_top_face;
            // two's complement magnitude; the most negative value stays 2^31
            r0_vb     <= 32'(~i_item.vel_bottom_face) + 32'd1;
            r0_w      <= i_item.frac_center[15:0];
        end
    end

    // stage 1: displacement and fluid / empty length products
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_pt    <= r0_vt * r_dt;
            r1_pb    <= r0_vb * r_dt;
            r1_wf    <= r0_w * r_dy;
            r1_we    <= (17'(ONE_Q16) - {1'b0, r0_w}) * r_dy;
            r1_w     <= r0_w;
            r1_ctl_t <= r0_ctl_t;
            r1_ctl_b <= r0_ctl_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_tag[0]  <= i_item.cell_tag;
            r_kind[0] <= kind;
            r_tw[0]   <= n_ctl_t.wr;
            r_bw[0]   <= n_ctl_b.wr;
        end
        for (int k = 1; k < 6; k++) begin
            if (rdy[k]) begin
                r_tag[k]  <= r_tag[k-1];
                r_kind[k] <= r_kind[k-1];
                r_tw[k]   <= r_tw[k-1];
                r_bw[k]   <= r_bw[k-1];
            end
        end
    end

    slicvf_face u_face_top (
        .i_clk  (i_clk),
        .i_en   (rdy[5:2]),
        .i_ctl  (r1_ctl_t),
        .i_prod (r1_pt),
        .i_wf   (r1_wf),
        .i_we   (r1_we),
        .i_w    (r1_w),
        .i_dx   (r_dx),
        .o_flux (flux_t)
    );

    slicvf_face u_face_bot (
        .i_clk  (i_clk),
        .i_en   (rdy[5:2]),
        .i_ctl  (r1_ctl_b),
        .i_prod (r1_pb),
        .i_wf   (r1_wf),
        .i_we   (r1_we),
        .i_w    (r1_w),
        .i_dx   (r_dx),
        .o_flux (flux_b)
    );

    always_comb begin
        o_item.cell_tag_out   = r_tag[5];
        o_item.interface_case = r_kind[5];
        o_item.flux_top       = flux_t;
        o_item.top_written    = r_tw[5];
        o_item.flux_bottom    = flux_b;
        o_item.bottom_written = r_bw[5];
    end

    // checks
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output not blocked");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted beat lost at entry");

    a_top_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.top_written) |-> (o_item.flux_top == 32'd0))
        else $error("top flux set without flag");

    a_bot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.bottom_written) |-> (o_item.flux_bottom == 32'd0))
        else $error("bottom flux set without flag");

    a_flag_case: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_item.top_written || o_item.bottom_written)) |->
        (o_item.interface_case != KIND_NONE && o_item.interface_case != KIND_UNMATCHED))
        else $error("flux flagged for a cell without usable interface");

endmodule

// ===== hdl/slicvf_classify.sv =====
// ----------------------------------------------------------------------------
// slicvf_classify
// Sorts a cell into its SLIC interface case from the three fractions.
// ----------------------------------------------------------------------------
module slicvf_classify
    import slicvf_pkg::*;
(
    input  logic [16:0] i_frac_c,
    input  logic [16:0] i_frac_a,
    input  logic [16:0] i_frac_b,
    input  logic [14:0] i_tol,
    output logic [2:0]  o_kind
);

    logic signed [18:0] one, tol, c, a, b, omc, oma, omb, omt;
    logic mixa, mixb, fea, feb;

    always_comb begin
        one  = 19'sd65536;
        tol  = signed'({4'b0, i_tol});
        c    = signed'({2'b0, i_frac_c});
        a    = signed'({2'b0, i_frac_a});
        b    = signed'({2'b0, i_frac_b});
        omc  = one - c;
        oma  = one - a;
        omb  = one - b;
        omt  = one - tol;
        mixa = (a > tol) && (oma > tol);
        mixb = (b > tol) && (omb > tol);
        fea  = (a <= tol) && (oma <= tol);
        feb  = (b <= tol) && (omb <= tol);
        o_kind = KIND_NONE;
        if ((c < omt) && (omc < omt)) begin
            if ((mixa && mixb) || (fea && feb) || (fea && mixb) || (mixa && feb)) begin
                o_kind = KIND_TYPE1;
            end else if (((b > tol) && (a <= tol)) || ((b <= tol) && (a > tol)) ||
                         ((omb > tol) && (oma <= tol)) ||
                         ((omb <= tol) && (oma > tol))) begin
                o_kind = (b > a) ? KIND_II_BELOW : KIND_II_ABOVE;
            end else if (((a <= tol) && (b <= tol) && (oma > tol) && (omb > tol)) ||
                         ((a > tol) && (b > tol) && (oma <= tol) && (omb <= tol))) begin
                o_kind = ((a > 0) && (b > 0)) ? KIND_III_FLUID : KIND_III_GAP;
            end else begin
                o_kind = KIND_UNMATCHED;
            end
        end
    end

endmodule

// ===== hdl/slicvf_face.sv =====
// ----------------------------------------------------------------------------
// slicvf_face
// Flux for one face: profile select, d*w, split d x dx product, saturate.
// ----------------------------------------------------------------------------
module slicvf_face
    import slicvf_pkg::*;
(
    input  logic        i_clk,
    input  logic [3:0]  i_en,      // load enables, stages 2..5
    input  t_face_ctl   i_ctl,
    input  logic [63:0] i_prod,    // |v| * dt
    input  logic [47:0] i_wf,      // w * dy
    input  logic [48:0] i_we,      // (ONE - w) * dy
    input  logic [15:0] i_w,
    input  logic [31:0] i_dx,
    output logic [31:0] o_flux
);

    logic [47:0] d, lf, le, hf, he, hle, hel, n_p, n_q;
    logic [47:0] r2_p, r2_q, r3_p, r3_q;
    logic [47:0] r2_dwlo;
    logic [31:0] r2_dwhi;
    logic        r2_k1, r2_wr, r3_wr, r4_wr;
    logic [63:0] dw;
    logic [63:0] r4_plo, r4_qlo;
    logic [47:0] r4_phi, r4_qhi;
    logic [79:0] tp, tq;
    logic [64:0] m;
    logic [31:0] r_flux;

    always_comb begin
        d   = i_prod[63:16];
        lf  = {16'b0, i_wf[47:16]};
        hf  = {17'b0, i_wf[47:17]};
        le  = {15'b0, i_we[48:16]};
        he  = {16'b0, i_we[48:17]};
        hle = hf + le;
        hel = he + lf;
        n_p = '0;
        n_q = '0;
        case (i_ctl.prof)
            KIND_TYPE1: begin
                n_p = '0;
            end
            KIND_II_BELOW: begin
                if (i_ctl.ff) begin
                    n_p = (d < lf) ? d : lf;
                end else begin
                    n_p = (d > le) ? d - le : '0;
                end
            end
            KIND_III_FLUID: begin
                if (d < hf) begin
                    n_p = d;
                end else begin
                    n_p = hf;
                    if (d >= hle) n_q = d - hle;
                end
            end
            default: begin
                if (d < he)       n_p = '0;
                else if (d < hel) n_p = d - he;
                else              n_p = lf;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r2_p    <= n_p;
            r2_q    <= n_q;
            r2_dwlo <= {16'b0, d[31:0]} * {32'b0, i_w};
            r2_dwhi <= 32'(d[47:32] * i_w);
            r2_k1   <= (i_ctl.prof == KIND_TYPE1);
            r2_wr   <= i_ctl.wr;
        end
    end

    // type I: d*w recombined, then scaled by dx like the others
    assign dw = {16'b0, r2_dwlo} + {r2_dwhi, 32'b0};

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r3_p  <= r2_k1 ? dw[63:16] : r2_p;
            r3_q  <= r2_q;
            r3_wr <= r2_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r4_plo <= r3_p[31:0] * i_dx;
            r4_phi <= r3_p[47:32] * i_dx;
            r4_qlo <= r3_q[31:0] * i_dx;
            r4_qhi <= r3_q[47:32] * i_dx;
            r4_wr  <= r3_wr;
        end
    end

    always_comb begin
        tp = {16'b0, r4_plo} + {r4_phi, 32'b0};
        tq = {16'b0, r4_qlo} + {r4_qhi, 32'b0};
        m  = {1'b0, tp[79:16]} + {1'b0, tq[79:16]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            if (!r4_wr)          r_flux <= '0;
            else if (|m[64:32])  r_flux <= '1;
            else                 r_flux <= m[31:0];
        end
    end

    assign o_flux = r_flux;

endmodule

// ===== verif/slic_vof_vertical_flux_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slic_vof_vertical_flux_checker
// Watches the cell and result channels and the register port, predicts each
// cell's SLIC case and face fluxes, and compares every result beat in order.
// ----------------------------------------------------------------------------
module slic_vof_vertical_flux_checker
    import slicvf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  t_in_item    i_item,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_item,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam logic [63:0] WIDE_CAP = 64'hFFFF_FFFF_FFFF;

    logic [14:0] tol_q;
    logic [31:0] dt_q, dx_q, dy_q;
    t_out_item   flux_queue[$];

    assign o_pending = flux_queue.size();

    function automatic logic [63:0] mul_q16(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        if (p[127:64] != 0) return WIDE_CAP;
        return p[63:0] >> 16;
    endfunction

    function automatic logic [31:0] face_flux(logic [2:0] prof, logic fluid_out,
                                              logic [63:0] d, logic [63:0] w);
        logic [63:0] lf, le, hf, he, r;
        lf = (w * dy_q) >> 16;
        le = ((64'd65536 - w) * dy_q) >> 16;
        hf = (w * dy_q) >> 17;
        he = ((64'd65536 - w) * dy_q) >> 17;
        if (prof == KIND_TYPE1)
            r = mul_q16(mul_q16(d, w), dx_q);
        else if (prof == KIND_II_BELOW) begin
            if (fluid_out) r = (d < lf) ? mul_q16(d, dx_q) : mul_q16(lf, dx_q);
            else           r = (d > le) ? mul_q16(d - le, dx_q) : 64'd0;
        end else if (prof == KIND_III_FLUID) begin
            if (d < hf)           r = mul_q16(d, dx_q);
            else if (d < hf + le) r = mul_q16(hf, dx_q);
            else                  r = mul_q16(hf, dx_q) + mul_q16(d - (hf + le), dx_q);
        end else begin
            if (d < he)           r = 0;
            else if (d < he + lf) r = mul_q16(d - he, dx_q);
            else                  r = mul_q16(lf, dx_q);
        end
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function automatic t_out_item predict_flux(t_in_item it);
        t_out_item   res;
        longint      tol, c, a, b;
        logic        mixa, mixb, fea, feb;
        logic [2:0]  kind, prof;
        logic [63:0] vt, vb, d;
        tol  = tol_q;
        c    = it.frac_center;
        a    = it.frac_above;
        b    = it.frac_below;
        kind = KIND_NONE;
        res  = '0;
        res.cell_tag_out = it.cell_tag;
        if (c < 65536 - tol && (65536 - c) < 65536 - tol) begin
            mixa = a > tol && (65536 - a) > tol;
            mixb = b > tol && (65536 - b) > tol;
            fea  = a <= tol && (65536 - a) <= tol;
            feb  = b <= tol && (65536 - b) <= tol;
            if ((mixa && mixb) || (fea && feb) || (fea && mixb) || (mixa && feb))
                kind = KIND_TYPE1;
            else if ((b > tol && a <= tol) || (b <= tol && a > tol) ||
                     ((65536 - b) > tol && (65536 - a) <= tol) ||
                     ((65536 - b) <= tol && (65536 - a) > tol))
                kind = (b > a) ? KIND_II_BELOW : KIND_II_ABOVE;
            else if ((a <= tol && b <= tol && (65536 - a) > tol && (65536 - b) > tol) ||
                     (a > tol && b > tol && (65536 - a) <= tol && (65536 - b) <= tol))
                kind = (a > 0 && b > 0) ? KIND_III_FLUID : KIND_III_GAP;
            else
                kind = KIND_UNMATCHED;
        end
        res.interface_case = kind;
        if (kind != KIND_NONE && kind != KIND_UNMATCHED) begin
            prof = (kind == KIND_II_ABOVE) ? KIND_II_BELOW : kind;
            if (it.vel_top_face > 0) begin
                vt = 64'(unsigned'(it.vel_top_face));
                d  = (vt * dt_q) >> 16;
                res.flux_top    = face_flux(prof, kind == KIND_II_ABOVE, d, 64'(c));
                res.top_written = 1'b1;
            end
            if (it.vel_bottom_face < 0) begin
                vb = 64'd0 - 64'(it.vel_bottom_face);
                d  = (vb * dt_q) >> 16;
                res.flux_bottom    = face_flux(prof, kind == KIND_II_BELOW, d, 64'(c));
                res.bottom_written = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            tol_q    <= TOL_RESET;
            dt_q     <= DT_RESET;
            dx_q     <= DX_RESET;
            dy_q     <= DY_RESET;
            o_errors <= 0;
            flux_queue.delete();
        end else begin
            if (i_valid && !i_stall_in)
                flux_queue.push_back(predict_flux(i_item));
            if (i_out_valid && !i_out_stall) begin
                if (flux_queue.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result beat %p", i_out_item);
                    o_errors <= o_errors + 1;
                end else begin
                    want = flux_queue.pop_front();
                    if (want !== i_out_item) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %p got %p", want, i_out_item);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TOL: tol_q <= i_cfg_data[14:0];
                    CFG_DT:  dt_q  <= i_cfg_data;
                    CFG_DX:  dx_q  <= i_cfg_data;
                    CFG_DY:  dy_q  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== verif/slic_vof_vertical_flux_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slic_vof_vertical_flux_tb
// Drives directed and random cells through several register settings with
// bursty input and random output stall; the checker compares every result.
// ----------------------------------------------------------------------------
module slic_vof_vertical_flux_tb;
    import slicvf_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid, in_stall, out_valid;
    logic        out_stall = 1'b0;
    t_in_item    in_item;
    t_out_item   out_item;
    logic        cfg_valid, cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;
    int          errors, pending;
    int          cycles = 0;
    int          stall_mode = 0;

    slic_vof_vertical_flux u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_item(in_item),
        .o_valid(out_valid), .i_stall(out_stall), .o_item(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    slic_vof_vertical_flux_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_stall_in(in_stall), .i_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("slic_vof_vertical_flux test failed");
            $finish;
        end
    end

    // output stall pattern: phases of none, light and heavy stall
    always @(posedge clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_cell(t_in_item it);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (n != 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [16:0] pick_frac(logic [14:0] tol);
        case ($urandom_range(0, 7))
            0:       return 17'd0;
            1:       return 17'd65536;
            2:       return 17'(tol) + 17'($urandom_range(0, 1));
            3:       return 17'd65536 - 17'(tol) - 17'($urandom_range(0, 1));
            4:       return 17'($urandom_range(0, 131071));
            5:       return 17'($urandom_range(0, 200));
            6:       return 17'd65536 - 17'($urandom_range(0, 200));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [31:0] pick_vel();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'd0;
            3:       return 32'($urandom_range(0, 1 << 20));
            4:       return -32'($urandom_range(0, 1 << 20));
            default: return $urandom;
        endcase
    endfunction

    task automatic drain_and_wait();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial begin
        t_in_item    it;
        logic [14:0] tol;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_TOL;
        cfg_data   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cells at reset settings
        tol = TOL_RESET;
        for (int k = 0; k < 24; k++) begin
            it.cell_tag    = (k == 0) ? 16'hFFFF : 16'(k);
            it.frac_center = (k < 3) ? 17'(k * 65535 / 2) : 17'd32768 + 17'(k);
            it.frac_above  = (k % 4 == 0) ? 17'd0 : (k % 4 == 1) ? 17'd65536 :
                             (k % 4 == 2) ? 17'd30000 : 17'h1FFFF;
            it.frac_below  = (k / 4 % 4 == 0) ? 17'd0 : (k / 4 % 4 == 1) ? 17'd65536 :
                             (k / 4 % 4 == 2) ? 17'd40000 : 17'd1;
            it.vel_top_face    = (k % 3 == 0) ? 32'h7FFF_FFFF : (k % 3 == 1) ? 32'sd0 : 32'sd700000;
            it.vel_bottom_face = (k % 2 == 0) ? 32'h8000_0000 : -32'sd900000;
            send_cell(it);
        end
        drain_and_wait();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: tol = 15'd0;
                1: tol = 15'd32767;
                default: tol = 15'($urandom_range(0, 2000));
            endcase
            write_reg(CFG_TOL, {17'($urandom), tol});
            write_reg(CFG_DT, (ph == 0) ? 32'hFFFF_FFFF : (ph == 1) ? 32'd0 :
                              32'($urandom_range(0, 1 << 18)));
            write_reg(CFG_DX, (ph == 0) ? 32'hFFFF_FFFF : (ph == 1) ? 32'd0 :
                              32'($urandom_range(1 << 12, 1 << 20)));
            write_reg(CFG_DY, (ph == 0) ? 32'hFFFF_FFFF : (ph == 1) ? 32'd0 :
                              ((ph == 5) ? $urandom : 32'($urandom_range(1 << 12, 1 << 20))));
            write_reg(8'($urandom_range(4, 255)), $urandom);
            for (int n = 0; n < 100; n++) begin
                it.cell_tag        = 16'($urandom);
                it.frac_center     = pick_frac(tol);
                it.frac_above      = pick_frac(tol);
                it.frac_below      = pick_frac(tol);
                it.vel_top_face    = pick_vel();
                it.vel_bottom_face = pick_vel();
                send_cell(it);
                idle_gap();
            end
            drain_and_wait();
        end

        if (errors == 0)
            $display("slic_vof_vertical_flux test passed");
        else
            $display("slic_vof_vertical_flux test failed");
        $finish;
    end

endmodule
